[rtl/core/bam_pkg.sv]
`default_nettype none

package bam_pkg;

  // Length of the moving-average window.
  localparam int unsigned WINDOW_LEN = 10;

  // Field widths.
  localparam int unsigned PRESS_W = 17;
  localparam int unsigned ALT_W   = 24;

  // Fixed-point formats: log2 results carry 5 integer and 28 fraction bits,
  // the squaring mantissa is Q1.30 and the series sum is Q30 below 2.0.
  localparam int unsigned FRAC_W    = 28;
  localparam int unsigned LOG_W     = 33;
  localparam int unsigned MANT_W    = 31;
  localparam int unsigned EXP_SUM_W = 32;

  // Ring addressing and window sum widths.
  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned TOT_W  = ALT_W + $clog2(WINDOW_LEN);

  // Exact reciprocal for the window mean: floor(v / WINDOW_LEN) equals
  // (v * RING_RECIP) >> DIV_SH for every v below 2**TOT_W.
  localparam int unsigned DIV_SH = TOT_W + $clog2(WINDOW_LEN);
  localparam logic [TOT_W:0] RING_RECIP = (TOT_W + 1)'(
      ((64'd1 << DIV_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  // 1/5.255 in Q30, ln(2) in Q30 and the altitude scale in centimeters.
  localparam logic [27:0] INV_EXP  = 28'd204327654;
  localparam logic [29:0] LN2      = 30'd744261118;
  localparam logic [22:0] SCALE_CM = 23'd4433000;

  // Number of series terms after the constant one.
  localparam logic [3:0] EXP_TERMS = 4'd13;

  // floor(2**32 / k) for the series divisors k = 2 .. 13.
  localparam logic [31:0] EXP_RECIP [16] = '{
    32'd0,         32'd0,         32'd2147483648, 32'd1431655765,
    32'd1073741824, 32'd858993459, 32'd715827882,  32'd613566756,
    32'd536870912,  32'd477218588, 32'd429496729,  32'd390451572,
    32'd357913941,  32'd330382099, 32'd0,          32'd0
  };

endpackage

`default_nettype wire

[rtl/core/bam_log2.sv]
`default_nettype none

module bam_log2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bam_pkg::PRESS_W-1:0] x_i,
  output logic                        done_o,
  output logic [bam_pkg::LOG_W-1:0]   log_o
);
  import bam_pkg::*;

  logic                    busy_q;
  logic                    done_q;
  logic [4:0]              cnt_q;
  logic [4:0]              exp_q;
  logic [MANT_W-1:0]       mant_q;
  logic [FRAC_W-1:0]       frac_q;
  logic [4:0]              top_bit;
  logic [2*MANT_W-1:0]     square;
  logic [MANT_W:0]         sq_q30;

  // Position of the highest set bit gives the integer part.
  always_comb begin
    top_bit = '0;
    for (int i = 1; i < PRESS_W; i++) begin
      if (x_i[i]) begin
        top_bit = 5'(i);
      end
    end
  end

  // One squaring step per cycle yields one fraction bit.
  assign square = (2 * MANT_W)'(mant_q) * (2 * MANT_W)'(mant_q);
  assign sq_q30 = square[2*MANT_W-1:30];

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(FRAC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Mantissa and fraction bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      exp_q  <= top_bit;
      mant_q <= {{(MANT_W - PRESS_W){1'b0}}, x_i} << (5'd30 - top_bit);
      frac_q <= '0;
    end else if (busy_q) begin
      frac_q <= {frac_q[FRAC_W-2:0], sq_q30[MANT_W]};
      mant_q <= sq_q30[MANT_W] ? sq_q30[MANT_W:1] : sq_q30[MANT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign log_o  = {exp_q, frac_q};

endmodule

`default_nettype wire

[rtl/core/bam_exp2.sv]
`default_nettype none

module bam_exp2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bam_pkg::FRAC_W-1:0]    f_i,
  output logic                          done_o,
  output logic [bam_pkg::EXP_SUM_W-1:0] sum_o
);
  import bam_pkg::*;

  typedef enum logic [4:0] {
    X_IDLE = 5'b00001,
    X_ARG  = 5'b00010,
    X_MUL  = 5'b00100,
    X_DIV  = 5'b01000,
    X_FIX  = 5'b10000
  } exp_state_e;

  exp_state_e             state_q;
  logic                   done_q;
  logic [3:0]             k_q;
  logic [FRAC_W-1:0]      f_q;
  logic [29:0]            x_q;
  logic [30:0]            term_q;
  logic [EXP_SUM_W-1:0]   sum_q;
  logic [60:0]            prod_q;
  logic [30:0]            t_q;
  logic [62:0]            rprod_q;
  logic [57:0]            arg_prod;
  logic [60:0]            prod_rnd;
  logic [30:0]            t_val;
  logic [30:0]            q0;
  logic [34:0]            rem;
  logic [30:0]            q_val;

  // Series argument x = f * ln2 and the rounded, truncated-divided term.
  always_comb begin
    arg_prod = 58'(f_q) * 58'(LN2);
    prod_rnd = prod_q + 61'(64'd1 << 29);
    t_val    = prod_rnd[60:30];
    q0       = rprod_q[62:32];
    rem      = 35'(t_q) - 35'(q0) * 35'(k_q);
    if (k_q == 4'd1) begin
      q_val = t_q;
    end else if (rem >= 35'(k_q)) begin
      q_val = q0 + 31'd1;
    end else begin
      q_val = q0;
    end
  end

  // Term sequencer: multiply, scale by reciprocal, correct and accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= X_IDLE;
      done_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        X_IDLE: begin
          if (start_i) begin
            state_q <= X_ARG;
          end
        end
        X_ARG: begin
          k_q     <= 4'd1;
          state_q <= X_MUL;
        end
        X_MUL: begin
          state_q <= X_DIV;
        end
        X_DIV: begin
          state_q <= X_FIX;
        end
        X_FIX: begin
          if (k_q == EXP_TERMS) begin
            done_q  <= 1'b1;
            state_q <= X_IDLE;
          end else begin
            k_q     <= k_q + 4'd1;
            state_q <= X_MUL;
          end
        end
        default: begin
          state_q <= X_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == X_IDLE && start_i) begin
      f_q <= f_i;
    end
    if (state_q == X_ARG) begin
      x_q    <= 30'((arg_prod + 58'(64'd1 << 27)) >> FRAC_W);
      term_q <= 31'(64'd1 << 30);
      sum_q  <= EXP_SUM_W'(64'd1 << 30);
    end
    if (state_q == X_MUL) begin
      prod_q <= 61'(term_q) * 61'(x_q);
    end
    if (state_q == X_DIV) begin
      t_q     <= t_val;
      rprod_q <= 63'(t_val) * 63'(EXP_RECIP[k_q]);
    end
    if (state_q == X_FIX) begin
      term_q <= q_val;
      sum_q  <= sum_q + EXP_SUM_W'(q_val);
    end
  end

  assign done_o = done_q;
  assign sum_o  = sum_q;

endmodule

`default_nettype wire

[rtl/core/bam_ring.sv]
`default_nettype none

module bam_ring (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [bam_pkg::ALT_W-1:0] raw_i,
  output logic                             done_o,
  output logic signed [bam_pkg::ALT_W-1:0] smooth_o
);
  import bam_pkg::*;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_UPD  = 4'b0010,
    R_MUL  = 4'b0100,
    R_OUT  = 4'b1000
  } ring_state_e;

  ring_state_e               state_q;
  logic [ALT_W-1:0]          ring_mem [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]     vld_q;
  logic [SLOT_W-1:0]         slot_q;
  logic [ALT_W-1:0]          rd_data_q;
  logic                      rd_vld_q;
  logic signed [ALT_W-1:0]   raw_q;
  logic signed [TOT_W-1:0]   total_q;
  logic                      tot_neg_q;
  logic [2*TOT_W:0]          div_prod_q;
  logic signed [ALT_W-1:0]   old_val;
  logic [TOT_W-1:0]          tot_mag;
  logic [TOT_W-1:0]          div_num;
  logic [ALT_W-1:0]          quot;
  logic                      rd_en;
  logic                      wr_en;

  assign rd_en = (state_q == R_IDLE) && start_i;
  assign wr_en = (state_q == R_UPD);

  // Entries never written since reset count as zero.
  assign old_val = rd_vld_q ? $signed(rd_data_q) : '0;

  // Rounded mean: magnitude plus half the window, then the reciprocal.
  always_comb begin
    tot_mag = total_q[TOT_W-1] ? TOT_W'(-total_q) : TOT_W'(total_q);
    div_num = tot_mag + TOT_W'(WINDOW_LEN / 2);
    quot    = ALT_W'(div_prod_q >> DIV_SH);
  end

  // Window memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= ring_mem[slot_q];
      rd_vld_q  <= vld_q[slot_q];
      raw_q     <= raw_i;
    end
    if (wr_en) begin
      ring_mem[slot_q] <= raw_q;
    end
    if (state_q == R_MUL) begin
      tot_neg_q  <= total_q[TOT_W-1];
      div_prod_q <= (2 * TOT_W + 1)'(div_num) * (2 * TOT_W + 1)'(RING_RECIP);
    end
  end

  // Read-modify-write sequence and window bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      vld_q   <= '0;
      slot_q  <= '0;
      total_q <= '0;
    end else begin
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            state_q <= R_UPD;
          end
        end
        R_UPD: begin
          total_q       <= total_q - TOT_W'(old_val) + TOT_W'(raw_q);
          vld_q[slot_q] <= 1'b1;
          if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
            slot_q <= '0;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
          state_q <= R_MUL;
        end
        R_MUL: begin
          state_q <= R_OUT;
        end
        R_OUT: begin
          state_q <= R_IDLE;
        end
        default: begin
          state_q <= R_IDLE;
        end
      endcase
    end
  end

  assign done_o   = (state_q == R_OUT);
  assign smooth_o = tot_neg_q ? -$signed(quot) : $signed(quot);

endmodule

`default_nettype wire

[rtl/core/baro_altitude_moving_average.sv]
`default_nettype none

// Barometric relative altitude with a moving-average smoother. The first
// nonzero pressure reading after reset becomes the baseline and produces no
// output transaction; a zero reading before that is dropped. Every later
// reading produces one output transaction with the raw altitude in
// centimeters, 4433000 * (1 - (p / baseline)^(1/5.255)) saturated to signed
// 24 bits, and the rounded mean of the last WINDOW_LEN raw values, where
// window entries not yet written count as zero. One reading is processed at
// a time. A nonzero reading runs through the bit-serial log2 squaring loop
// and the thirteen terms of the exp2 series, each a multiply, a reciprocal
// scaling and a correction step. A zero reading after the baseline skips
// both. The next reading is accepted from the cycle after the result is
// handed over, and a baseline capture holds off the next reading until the
// log2 loop is done. A finished result waits in the sequencer, adding stall
// cycles, only while the output register still holds a stalled result. The
// next reading is accepted while the previous result still waits in the
// output register.
module baro_altitude_moving_average (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bam_pkg::PRESS_W-1:0]      pressure_pa_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bam_pkg::ALT_W-1:0] altitude_raw_cm_o,
  output logic signed [bam_pkg::ALT_W-1:0] altitude_smooth_cm_o
);
  import bam_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_BASE     = 11'b00000000010,
    ST_LOGP     = 11'b00000000100,
    ST_MULK_LO  = 11'b00000001000,
    ST_MULK_HI  = 11'b00000010000,
    ST_EXP      = 11'b00000100000,
    ST_DIFF     = 11'b00001000000,
    ST_SCALE_LO = 11'b00010000000,
    ST_SCALE_HI = 11'b00100000000,
    ST_RING     = 11'b01000000000,
    ST_DONE     = 11'b10000000000
  } top_state_e;

  top_state_e               state_q;
  logic [PRESS_W-1:0]       base_q;
  logic [LOG_W-1:0]         log_base_q;
  logic [LOG_W-1:0]         mag_q;
  logic                     neg_q;
  logic [44:0]              kp_q;
  logic [2:0]               n_q;
  logic                     yf_nz_q;
  logic [FRAC_W-1:0]        exp_arg_q;
  logic                     exp_start_q;
  logic [37:0]              power_q;
  logic                     diff_neg_q;
  logic [37:0]              smag_q;
  logic [41:0]              sp_q;
  logic signed [ALT_W-1:0]  raw_q;
  logic                     ring_start_q;
  logic signed [ALT_W-1:0]  smooth_q;
  logic                     out_valid_q;
  logic signed [ALT_W-1:0]  out_raw_q;
  logic signed [ALT_W-1:0]  out_smooth_q;

  logic                     in_accept;
  logic                     log_start;
  logic                     log_done;
  logic [LOG_W-1:0]         log_val;
  logic                     exp_done;
  logic [EXP_SUM_W-1:0]     exp_sum;
  logic                     ring_done;
  logic signed [ALT_W-1:0]  ring_smooth;
  logic                     out_free;

  logic signed [LOG_W:0]    ldiff;
  logic [LOG_W-1:0]         lmag;
  logic [60:0]              kfull;
  logic [30:0]              y_val;
  logic [3:0]               nn;
  logic [32:0]              rnd_sum;
  logic [37:0]              power_val;
  logic signed [38:0]       pdiff;
  logic [61:0]              sfull;
  logic [31:0]              amag;
  logic signed [ALT_W-1:0]  sat_val;

  // Input transactions are taken only between readings.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign log_start  = in_accept && (pressure_pa_i != '0);
  assign out_free   = !out_valid_q || !out_stall_i;

  bam_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (pressure_pa_i),
    .done_o  (log_done),
    .log_o   (log_val)
  );

  bam_exp2 u_exp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start_q),
    .f_i     (exp_arg_q),
    .done_o  (exp_done),
    .sum_o   (exp_sum)
  );

  bam_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ring_start_q),
    .raw_i    (raw_q),
    .done_o   (ring_done),
    .smooth_o (ring_smooth)
  );

  // Log ratio magnitude and its scaling by the inverse exponent.
  always_comb begin
    ldiff = $signed({1'b0, log_val}) - $signed({1'b0, log_base_q});
    lmag  = ldiff[LOG_W] ? LOG_W'(-ldiff) : ldiff[LOG_W-1:0];
    kfull = ((61'(mag_q[32:17]) * 61'(INV_EXP)) << 17) + 61'(kp_q)
            + 61'(64'd1 << 29);
    y_val = kfull[60:30];
  end

  // Power from the fractional exponent and the integer shift.
  always_comb begin
    nn      = {1'b0, n_q} + {3'b000, yf_nz_q};
    rnd_sum = 33'(exp_sum);
    if (nn != 4'd0) begin
      rnd_sum = 33'(exp_sum) + (33'd1 << (nn - 4'd1));
    end
    if (!neg_q) begin
      power_val = 38'(exp_sum) << n_q;
    end else begin
      power_val = 38'(rnd_sum >> nn);
    end
  end

  // Altitude scale with rounding and saturation.
  always_comb begin
    pdiff = $signed(39'(64'd1 << 30)) - $signed({1'b0, power_q});
    sfull = ((62'(smag_q[37:19]) * 62'(SCALE_CM)) << 19) + 62'(sp_q)
            + 62'(64'd1 << 29);
    amag  = sfull[61:30];
    if (!diff_neg_q) begin
      if (amag > 32'd8388607) begin
        sat_val = ALT_W'(24'h7FFFFF);
      end else begin
        sat_val = $signed(amag[ALT_W-1:0]);
      end
    end else begin
      if (amag > 32'd8388608) begin
        sat_val = ALT_W'(24'h800000);
      end else begin
        sat_val = -$signed(amag[ALT_W-1:0]);
      end
    end
  end

  // Reading sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      base_q       <= '0;
      exp_start_q  <= 1'b0;
      ring_start_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      exp_start_q  <= 1'b0;
      ring_start_q <= 1'b0;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            if (base_q == '0) begin
              if (pressure_pa_i != '0) begin
                base_q  <= pressure_pa_i;
                state_q <= ST_BASE;
              end
            end else if (pressure_pa_i == '0) begin
              state_q <= ST_DIFF;
            end else begin
              state_q <= ST_LOGP;
            end
          end
        end
        ST_BASE: begin
          if (log_done) begin
            state_q <= ST_IDLE;
          end
        end
        ST_LOGP: begin
          if (log_done) begin
            state_q <= ST_MULK_LO;
          end
        end
        ST_MULK_LO: begin
          state_q <= ST_MULK_HI;
        end
        ST_MULK_HI: begin
          exp_start_q <= 1'b1;
          state_q     <= ST_EXP;
        end
        ST_EXP: begin
          if (exp_done) begin
            state_q <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          state_q <= ST_SCALE_LO;
        end
        ST_SCALE_LO: begin
          state_q <= ST_SCALE_HI;
        end
        ST_SCALE_HI: begin
          ring_start_q <= 1'b1;
          state_q      <= ST_RING;
        end
        ST_RING: begin
          if (ring_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_accept && pressure_pa_i == '0) begin
      power_q <= '0;
    end
    if (state_q == ST_BASE && log_done) begin
      log_base_q <= log_val;
    end
    if (state_q == ST_LOGP && log_done) begin
      neg_q <= ldiff[LOG_W];
      mag_q <= lmag;
    end
    if (state_q == ST_MULK_LO) begin
      kp_q <= 45'(mag_q[16:0]) * 45'(INV_EXP);
    end
    if (state_q == ST_MULK_HI) begin
      n_q       <= y_val[30:28];
      yf_nz_q   <= (y_val[27:0] != '0);
      exp_arg_q <= neg_q ? (28'd0 - y_val[27:0]) : y_val[27:0];
    end
    if (state_q == ST_EXP && exp_done) begin
      power_q <= power_val;
    end
    if (state_q == ST_DIFF) begin
      diff_neg_q <= pdiff[38];
      smag_q     <= pdiff[38] ? 38'(-pdiff) : pdiff[37:0];
    end
    if (state_q == ST_SCALE_LO) begin
      sp_q <= 42'(smag_q[18:0]) * 42'(SCALE_CM);
    end
    if (state_q == ST_SCALE_HI) begin
      raw_q <= sat_val;
    end
    if (state_q == ST_RING && ring_done) begin
      smooth_q <= ring_smooth;
    end
    if (state_q == ST_DONE && out_free) begin
      out_raw_q    <= raw_q;
      out_smooth_q <= smooth_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign altitude_raw_cm_o    = out_raw_q;
  assign altitude_smooth_cm_o = out_smooth_q;

  // The log unit reports only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> (state_q == ST_BASE || state_q == ST_LOGP))
    else $error("log2 result arrived outside a log wait");

  // The series unit reports only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_done |-> (state_q == ST_EXP))
    else $error("exp2 result arrived outside the series wait");

  // The window update finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_done |-> (state_q == ST_RING))
    else $error("window update finished outside the ring wait");

  // A finished reading reaches the output as soon as the register is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_o && state_q == ST_IDLE))
    else $error("finished reading was not handed to the output");

endmodule

`default_nettype wire

[verif/baro_altitude_moving_average_tb.sv]
`default_nettype none

module baro_altitude_moving_average_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bam_pkg::*;

  typedef struct packed {
    logic signed [ALT_W-1:0] raw_cm;
    logic signed [ALT_W-1:0] smooth_cm;
  } altitude_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [PRESS_W-1:0]      pressure_pa_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [ALT_W-1:0] altitude_raw_cm_o;
  logic signed [ALT_W-1:0] altitude_smooth_cm_o;

  baro_altitude_moving_average i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .pressure_pa_i       (pressure_pa_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .altitude_raw_cm_o   (altitude_raw_cm_o),
    .altitude_smooth_cm_o(altitude_smooth_cm_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow state of the altitude computation.
  longint unsigned base_press;
  longint          alt_ring [WINDOW_LEN];
  int unsigned     ring_slot;
  longint          ring_sum;
  altitude_t       pending_alt [$];
  int unsigned     mismatches;
  int unsigned     results_seen;
  int unsigned     readings_sent;
  bit              quiet;

  // Q28 log2 by repeated squaring of the normalized mantissa.
  function automatic longint unsigned log2_fix(longint unsigned x);
    longint unsigned e;
    longint unsigned m;
    longint unsigned frac;
    e = 0;
    frac = 0;
    while (e < 16 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int i = 0; i < FRAC_W; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (e << FRAC_W) | frac;
  endfunction

  // Q30 value of 2^f for a Q28 fraction, by a truncated Taylor series.
  function automatic longint unsigned exp2_fix(longint unsigned f);
    longint unsigned x;
    longint unsigned sum;
    longint unsigned term;
    x = (f * 64'd744261118 + (64'd1 << 27)) >> FRAC_W;
    sum = 64'd1 << 30;
    term = 64'd1 << 30;
    for (longint unsigned k = 1; k <= 13; k++) begin
      term = ((term * x + (64'd1 << 29)) >> 30) / k;
      sum += term;
    end
    return sum;
  endfunction

  function automatic longint altitude_cm(longint unsigned p, longint unsigned b);
    longint unsigned power;
    longint unsigned mag;
    longint unsigned y;
    longint unsigned yf;
    longint unsigned n;
    longint          d;
    longint          diff;
    longint          alt;
    if (p == 0) begin
      power = 0;
    end else begin
      d = longint'(log2_fix(p)) - longint'(log2_fix(b));
      mag = (d < 0) ? longint'(-d) : d;
      y = (mag * 64'd204327654 + (64'd1 << 29)) >> 30;
      yf = y & ((64'd1 << FRAC_W) - 1);
      if (d >= 0) begin
        power = exp2_fix(yf) << (y >> FRAC_W);
      end else begin
        n = (y >> FRAC_W) + ((yf != 0) ? 1 : 0);
        power = exp2_fix(((64'd1 << FRAC_W) - yf) & ((64'd1 << FRAC_W) - 1));
        if (n != 0) power = (power + (64'd1 << (n - 1))) >> n;
      end
    end
    diff = longint'(64'd1 << 30) - longint'(power);
    mag = (diff < 0) ? longint'(-diff) : diff;
    alt = longint'((mag * 64'd4433000 + (64'd1 << 29)) >> 30);
    if (diff < 0) alt = -alt;
    if (alt > 8388607) alt = 8388607;
    if (alt < -8388608) alt = -8388608;
    return alt;
  endfunction

  // Advances the shadow state by one accepted reading.
  function automatic void predict_altitude(logic [PRESS_W-1:0] p);
    longint    raw;
    longint    avg;
    longint    mag;
    altitude_t res;
    if (base_press == 0) begin
      base_press = p;
      return;
    end
    raw = altitude_cm(p, base_press);
    ring_sum = ring_sum - alt_ring[ring_slot] + raw;
    alt_ring[ring_slot] = raw;
    ring_slot = (ring_slot + 1) % WINDOW_LEN;
    mag = (ring_sum < 0) ? -ring_sum : ring_sum;
    avg = (mag + WINDOW_LEN / 2) / WINDOW_LEN;
    if (ring_sum < 0) avg = -avg;
    res.raw_cm = raw[ALT_W-1:0];
    res.smooth_cm = avg[ALT_W-1:0];
    pending_alt.push_back(res);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  // Sends one reading and updates the prediction once it is accepted.
  task automatic send_reading(logic [PRESS_W-1:0] p);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pressure_pa_i <= p;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    predict_altitude(p);
    readings_sent++;
  endtask

  // Result-side back-pressure with short and occasional long stalls.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(99) < 20)
        stall_left <= ($urandom_range(99) < 90) ? $urandom_range(3, 1)
                                               : $urandom_range(80, 20);
    end
  end

  // Compare every output transaction with the oldest prediction.
  always @(negedge clk_i) begin
    altitude_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_alt.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result raw=%0d smooth=%0d",
                                       altitude_raw_cm_o, altitude_smooth_cm_o);
      end else begin
        want = pending_alt.pop_front();
        if (want.raw_cm !== altitude_raw_cm_o ||
            want.smooth_cm !== altitude_smooth_cm_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: raw exp %0d got %0d, smooth exp %0d got %0d",
                     want.raw_cm, altitude_raw_cm_o, want.smooth_cm,
                     altitude_smooth_cm_o);
        end
      end
    end
  end

  // Zero readings before the baseline are dropped; then a small baseline is taken.
  task automatic test_baseline_capture();
    send_reading('0);
    send_reading('0);
    send_reading(PRESS_W'($urandom_range(450, 1)));
  endtask

  // Edge readings: equal to baseline, zero, the extremes, and a back-to-back run.
  task automatic test_edge_readings();
    send_reading(PRESS_W'(base_press));
    send_reading('0);
    send_reading('1);
    send_reading(PRESS_W'(1));
    send_reading(PRESS_W'(base_press + 1));
    send_reading(PRESS_W'(base_press - 1));
    send_reading('1);
    send_reading(PRESS_W'(base_press * 2));
    send_reading(PRESS_W'(base_press / 2));
    quiet = 1'b1;
    for (int i = 0; i < 12; i++) send_reading(PRESS_W'($urandom_range(131071)));
    quiet = 1'b0;
  endtask

  // Random readings: near the baseline, full range, near the top, and a few zeros.
  task automatic test_random_readings();
    int unsigned r;
    logic [PRESS_W-1:0] p;
    for (int i = 0; i < 550; i++) begin
      r = $urandom_range(99);
      if (r < 40) p = PRESS_W'($urandom_range(131071));
      else if (r < 85) p = PRESS_W'($urandom_range(32'(base_press * 3 + 2)));
      else if (r < 93) p = '0;
      else p = PRESS_W'($urandom_range(131071, 120000));
      quiet = (i >= 200 && i < 240);
      send_reading(p);
    end
    quiet = 1'b0;
  endtask

  initial begin
    base_press = 0;
    ring_slot = 0;
    ring_sum = 0;
    mismatches = 0;
    results_seen = 0;
    readings_sent = 0;
    quiet = 1'b0;
    foreach (alt_ring[i]) alt_ring[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_baseline_capture();
    test_edge_readings();
    test_random_readings();
    in_valid_i <= 1'b0;
    while (pending_alt.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d readings against baseline %0d pa; checked %0d results.",
             readings_sent, base_press, results_seen);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_alt.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", pending_alt.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/core/bam_pkg.sv
rtl/core/bam_log2.sv
rtl/core/bam_exp2.sv
rtl/core/bam_ring.sv
rtl/core/baro_altitude_moving_average.sv
verif/baro_altitude_moving_average_tb.sv
